// File: rtl/core/wvbd_pkg.sv
// ----------------------------------------------------------------------------
// wvbd_pkg
// Shared types and constants for the window vote filter and blink detector.
// ----------------------------------------------------------------------------
package wvbd_pkg;

    localparam int NUM_PINS     = 16;
    localparam int COUNT_WIDTH  = 8;
    localparam int CHANGE_WIDTH = 16;
    localparam int CTRL_PINS    = 8;
    localparam int SAMPLE_W     = 8;
    localparam int WIN_W        = 8;
    localparam int TIME_W       = 32;
    localparam int BTHR_W       = 16;
    localparam int CMP_W        = 32;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;
    localparam logic [CHANGE_WIDTH-1:0] CHANGE_MAX = '1;

    typedef enum logic [2:0] {
        REG_NORMAL_WINDOW     = 3'd0,
        REG_NORMAL_THRESHOLD  = 3'd1,
        REG_CONTROL_WINDOW    = 3'd2,
        REG_CONTROL_THRESHOLD = 3'd3,
        REG_BLINK_INTERVAL    = 3'd4,
        REG_BLINK_THRESHOLD   = 3'd5
    } t_reg_idx;

    localparam logic [WIN_W-1:0]  RST_WINDOW     = 8'd9;
    localparam logic [WIN_W-1:0]  RST_THRESHOLD  = 8'd5;
    localparam logic [TIME_W-1:0] RST_INTERVAL   = 32'd1000;
    localparam logic [BTHR_W-1:0] RST_BLINK_THR  = 16'd3;

    typedef struct packed {
        logic [WIN_W-1:0]  normal_window;
        logic [WIN_W-1:0]  normal_threshold;
        logic [WIN_W-1:0]  control_window;
        logic [WIN_W-1:0]  control_threshold;
        logic [TIME_W-1:0] blink_interval;
        logic [BTHR_W-1:0] blink_threshold;
    } t_cfg;

    // per-request control broadcast to every lane
    typedef struct packed {
        logic              close;      // this sample closes the window
        logic              blink_run;  // blink detector runs (normal mode)
        logic              check;      // blink interval elapsed
        logic [WIN_W-1:0]  thr;
        logic [BTHR_W-1:0] blink_thr;
    } t_step_ctl;

endpackage

// File: rtl/core/window_vote_input_filter_blink_detect.sv
// ----------------------------------------------------------------------------
// window_vote_input_filter_blink_detect
// Windowed majority debounce of sixteen pins with a per-pin toggle detector.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+----------------------------------
//  sample   | in  | i_in_valid / o_in_ready   | i_pin_levels, i_mode, i_now_ms
//  result   | out | o_out_valid / i_out_ready | o_filtered_state, o_blink_flags,
//           |     |                           | o_interleaved_word, o_window_done
//  config   | in  | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  One request per cycle unless input stalls; its result is registered and shows in the next cycle.
//  Each request makes a single pass through the pin lanes, whose counters
//  all update together at the accepting edge.
//  A waiting result does not stall input while the consumer takes it the same
//  cycle; input stalls only when the result register is full and not taken.
//  Synchronous active-low reset clears all counters, the timer and the flags;
//  registers return to their defaults. No clearing pass is needed.
//
// ----------------------------------------------------------------------------
module window_vote_input_filter_blink_detect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample request
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [wvbd_pkg::NUM_PINS-1:0]   i_pin_levels,
    input  logic                            i_mode,
    input  logic [wvbd_pkg::TIME_W-1:0]     i_now_ms,
    // result
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [wvbd_pkg::NUM_PINS-1:0]   o_filtered_state,
    output logic [wvbd_pkg::NUM_PINS-1:0]   o_blink_flags,
    output logic [2*wvbd_pkg::NUM_PINS-1:0] o_interleaved_word,
    output logic                            o_window_done,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wvbd_pkg::ADDR_W-1:0]     paddr,
    input  logic [wvbd_pkg::DATA_W-1:0]     pwdata,
    output logic [wvbd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    wvbd_pkg::t_cfg                w_cfg;
    wvbd_pkg::t_step_ctl           w_ctl;
    logic                          w_accept;
    logic [wvbd_pkg::NUM_PINS-1:0] w_judged;
    logic [wvbd_pkg::NUM_PINS-1:0] w_filt;
    logic [wvbd_pkg::NUM_PINS-1:0] w_blink;

    assign w_accept = i_in_valid && o_in_ready;

    wvbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // shared window counter and blink timer
    wvbd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (i_mode),
        .i_now_ms (i_now_ms),
        .i_cfg    (w_cfg),
        .o_ctl    (w_ctl)
    );

    // one lane per pin; in control mode only the low pins are judged
    for (genvar g = 0; g < wvbd_pkg::NUM_PINS; g++) begin : g_lane
        assign w_judged[g] = !i_mode || (g < wvbd_pkg::CTRL_PINS);

        wvbd_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_judged (w_judged[g]),
            .i_pin    (i_pin_levels[g]),
            .i_ctl    (w_ctl),
            .o_filt   (w_filt[g]),
            .o_blink  (w_blink[g])
        );
    end

    wvbd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_filt      (w_filt),
        .i_blink     (w_blink),
        .i_done      (w_ctl.close),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_filt      (o_filtered_state),
        .o_blink     (o_blink_flags),
        .o_inter     (o_interleaved_word),
        .o_done      (o_window_done)
    );

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // control mode forces the upper filtered bits low
    a_ctrl_upper_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode && w_ctl.close) |=>
        (o_filtered_state[wvbd_pkg::NUM_PINS-1:wvbd_pkg::CTRL_PINS] == '0))
        else $error("upper filtered bits set after control-mode window");

    // control mode leaves the blink flags alone
    a_ctrl_blink_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode && o_out_valid) |=> (o_blink_flags == $past(o_blink_flags)))
        else $error("blink flags changed in control mode");

endmodule

// File: rtl/core/wvbd_cfg.sv
// ----------------------------------------------------------------------------
// wvbd_cfg
// APB register file holding window, threshold and blink settings.
// ----------------------------------------------------------------------------
module wvbd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wvbd_pkg::ADDR_W-1:0] paddr,
    input  logic [wvbd_pkg::DATA_W-1:0] pwdata,
    output logic [wvbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output wvbd_pkg::t_cfg              o_cfg
);

    wvbd_pkg::t_cfg r_cfg;
    wvbd_pkg::t_cfg n_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                wvbd_pkg::REG_NORMAL_WINDOW:     n_cfg.normal_window     = pwdata[7:0];
                wvbd_pkg::REG_NORMAL_THRESHOLD:  n_cfg.normal_threshold  = pwdata[7:0];
                wvbd_pkg::REG_CONTROL_WINDOW:    n_cfg.control_window    = pwdata[7:0];
                wvbd_pkg::REG_CONTROL_THRESHOLD: n_cfg.control_threshold = pwdata[7:0];
                wvbd_pkg::REG_BLINK_INTERVAL:    n_cfg.blink_interval    = pwdata;
                wvbd_pkg::REG_BLINK_THRESHOLD:   n_cfg.blink_threshold   = pwdata[15:0];
                default:                         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            wvbd_pkg::REG_NORMAL_WINDOW:     prdata = {24'd0, r_cfg.normal_window};
            wvbd_pkg::REG_NORMAL_THRESHOLD:  prdata = {24'd0, r_cfg.normal_threshold};
            wvbd_pkg::REG_CONTROL_WINDOW:    prdata = {24'd0, r_cfg.control_window};
            wvbd_pkg::REG_CONTROL_THRESHOLD: prdata = {24'd0, r_cfg.control_threshold};
            wvbd_pkg::REG_BLINK_INTERVAL:    prdata = r_cfg.blink_interval;
            wvbd_pkg::REG_BLINK_THRESHOLD:   prdata = {16'd0, r_cfg.blink_threshold};
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_window     <= wvbd_pkg::RST_WINDOW;
            r_cfg.normal_threshold  <= wvbd_pkg::RST_THRESHOLD;
            r_cfg.control_window    <= wvbd_pkg::RST_WINDOW;
            r_cfg.control_threshold <= wvbd_pkg::RST_THRESHOLD;
            r_cfg.blink_interval    <= wvbd_pkg::RST_INTERVAL;
            r_cfg.blink_threshold   <= wvbd_pkg::RST_BLINK_THR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/core/wvbd_seq.sv
// ----------------------------------------------------------------------------
// wvbd_seq
// Shared sample counter and blink interval timer; drives the lane controls.
// ----------------------------------------------------------------------------
module wvbd_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_mode,
    input  logic [wvbd_pkg::TIME_W-1:0] i_now_ms,
    input  wvbd_pkg::t_cfg              i_cfg,
    output wvbd_pkg::t_step_ctl         o_ctl
);

    logic [wvbd_pkg::SAMPLE_W-1:0] r_sample_cnt;
    logic [wvbd_pkg::SAMPLE_W-1:0] n_sample_cnt;
    logic [wvbd_pkg::TIME_W-1:0]   r_start;
    logic [wvbd_pkg::TIME_W-1:0]   n_start;
    logic [wvbd_pkg::SAMPLE_W:0]   w_next;
    logic [wvbd_pkg::WIN_W-1:0]    w_window;
    logic [wvbd_pkg::TIME_W-1:0]   w_elapsed;
    logic                          w_close;
    logic                          w_check;

    assign w_window  = i_mode ? i_cfg.control_window : i_cfg.normal_window;
    assign w_next    = {1'b0, r_sample_cnt} + 1'b1;
    // 9-bit compare: a window of 255 still closes once the count passes it
    assign w_close   = w_next > {1'b0, w_window};
    assign w_elapsed = i_now_ms - r_start;
    assign w_check   = !i_mode && (w_elapsed >= i_cfg.blink_interval);

    always_comb begin
        n_sample_cnt = r_sample_cnt;
        n_start      = r_start;
        if (i_accept) begin
            n_sample_cnt = w_close ? '0 : w_next[wvbd_pkg::SAMPLE_W-1:0];
            if (w_check) begin
                n_start = i_now_ms;
            end
        end
    end

    assign o_ctl.close     = w_close;
    assign o_ctl.blink_run = !i_mode;
    assign o_ctl.check     = w_check;
    assign o_ctl.thr       = i_mode ? i_cfg.control_threshold : i_cfg.normal_threshold;
    assign o_ctl.blink_thr = i_cfg.blink_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= '0;
            r_start      <= '0;
        end else begin
            r_sample_cnt <= n_sample_cnt;
            r_start      <= n_start;
        end
    end

endmodule

// File: rtl/core/wvbd_lane.sv
// ----------------------------------------------------------------------------
// wvbd_lane
// One pin: high counter, filtered bit, change counter and blink bit.
// ----------------------------------------------------------------------------
module wvbd_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_judged,   // pin counted in this mode
    input  logic                i_pin,
    input  wvbd_pkg::t_step_ctl i_ctl,
    output logic                o_filt,     // filtered bit after this request
    output logic                o_blink     // blink bit after this request
);

    logic [wvbd_pkg::COUNT_WIDTH-1:0]  r_cnt;
    logic [wvbd_pkg::COUNT_WIDTH-1:0]  n_cnt;
    logic [wvbd_pkg::COUNT_WIDTH-1:0]  w_cnt_a;
    logic [wvbd_pkg::CHANGE_WIDTH-1:0] r_chg;
    logic [wvbd_pkg::CHANGE_WIDTH-1:0] n_chg;
    logic [wvbd_pkg::CHANGE_WIDTH-1:0] w_chg_a;
    logic                              r_filt;
    logic                              n_filt;
    logic                              r_prev;
    logic                              n_prev;
    logic                              r_blink;
    logic                              n_blink;
    logic                              w_inv;

    always_comb begin
        w_cnt_a = r_cnt;
        if (i_judged && i_pin && (r_cnt != wvbd_pkg::COUNT_MAX)) begin
            w_cnt_a = r_cnt + 1'b1;
        end

        n_cnt  = w_cnt_a;
        n_filt = r_filt;
        if (i_ctl.close) begin
            if (i_judged) begin
                n_filt = wvbd_pkg::CMP_W'(w_cnt_a) > wvbd_pkg::CMP_W'(i_ctl.thr);
                n_cnt  = '0;
            end else begin
                n_filt = 1'b0;   // unjudged pin reads low, count kept
            end
        end

        w_inv   = !n_filt;
        w_chg_a = r_chg;
        n_chg   = r_chg;
        n_blink = r_blink;
        n_prev  = r_prev;
        if (i_ctl.blink_run) begin
            if ((w_inv != r_prev) && (r_chg != wvbd_pkg::CHANGE_MAX)) begin
                w_chg_a = r_chg + 1'b1;
            end
            n_chg = w_chg_a;
            if (i_ctl.check) begin
                n_blink = wvbd_pkg::CMP_W'(w_chg_a) > wvbd_pkg::CMP_W'(i_ctl.blink_thr);
                n_chg   = '0;
            end
            n_prev = w_inv;
        end
    end

    assign o_filt  = n_filt;
    assign o_blink = n_blink;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_chg   <= '0;
            r_filt  <= 1'b0;
            r_prev  <= 1'b0;
            r_blink <= 1'b0;
        end else if (i_accept) begin
            r_cnt   <= n_cnt;
            r_chg   <= n_chg;
            r_filt  <= n_filt;
            r_prev  <= n_prev;
            r_blink <= n_blink;
        end
    end

endmodule

// File: rtl/core/wvbd_merge.sv
// ----------------------------------------------------------------------------
// wvbd_merge
// Gathers lane bits into result words and holds them in the output register.
// ----------------------------------------------------------------------------
module wvbd_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [wvbd_pkg::NUM_PINS-1:0]   i_filt,
    input  logic [wvbd_pkg::NUM_PINS-1:0]   i_blink,
    input  logic                            i_done,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic [wvbd_pkg::NUM_PINS-1:0]   o_filt,
    output logic [wvbd_pkg::NUM_PINS-1:0]   o_blink,
    output logic [2*wvbd_pkg::NUM_PINS-1:0] o_inter,
    output logic                            o_done
);

    logic                            r_valid;
    logic [wvbd_pkg::NUM_PINS-1:0]   r_filt;
    logic [wvbd_pkg::NUM_PINS-1:0]   r_blink;
    logic [2*wvbd_pkg::NUM_PINS-1:0] r_inter;
    logic [2*wvbd_pkg::NUM_PINS-1:0] n_inter;
    logic                            r_done;

    always_comb begin
        for (int i = 0; i < wvbd_pkg::NUM_PINS; i++) begin
            n_inter[2*i]   = !i_filt[i];
            n_inter[2*i+1] = i_blink[i];
        end
    end

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_filt      = r_filt;
    assign o_blink     = r_blink;
    assign o_inter     = r_inter;
    assign o_done      = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_filt  <= i_filt;
            r_blink <= i_blink;
            r_inter <= n_inter;
            r_done  <= i_done;
        end
    end

endmodule
